### rtl/core/cyclic_ring_successor_builder_core_assert.svh
// Assertion macros for the cyclic ring successor builder checker.
`ifndef CYCLIC_RING_SUCCESSOR_BUILDER_CORE_ASSERT_SVH
`define CYCLIC_RING_SUCCESSOR_BUILDER_CORE_ASSERT_SVH

// Checked only while out of reset.
`define CRSB_ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define CRSB_ASSERT_ALL(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/crsb_pkg.sv
// Shared types, constants and functions of the cyclic ring successor builder.
package crsb_pkg;

  localparam int unsigned CRSB_MAX_SLOTS = 4096;

  localparam int unsigned COUNT_W    = 13;
  localparam int unsigned SEED_W     = 64;
  localparam int unsigned SLOT_IDX_W = 12;
  localparam int unsigned SUCC_W     = 12;

  localparam logic CMD_BUILD = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  localparam int unsigned RNG_SHL_A = 13;
  localparam int unsigned RNG_SHR_B = 7;
  localparam int unsigned RNG_SHL_C = 17;

  localparam int unsigned MOD_BITS_PER_CYC = 4;
  localparam int unsigned MOD_CYCLES       = SEED_W / MOD_BITS_PER_CYC;
  localparam int unsigned MOD_CNT_W        = $clog2(MOD_CYCLES);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_RNG,
    ST_MOD,
    ST_SWAP_A,
    ST_SWAP_B,
    ST_LINK0,
    ST_LINK,
    ST_LINK_LAST,
    ST_RESP
  } ctrl_state_t;

  typedef struct packed {
    logic              valid;
    logic [SUCC_W-1:0] successor;
    logic              status;
  } resp_t;

  function automatic logic [SEED_W-1:0] rng_step(input logic [SEED_W-1:0] s);
    logic [SEED_W-1:0] a;
    logic [SEED_W-1:0] b;
    a = s ^ (s << RNG_SHL_A);
    b = a ^ (a >> RNG_SHR_B);
    return b ^ (b << RNG_SHL_C);
  endfunction

endpackage

### rtl/core/crsb_if.sv
// Request and response channel interfaces of the ring successor builder.
interface crsb_in_if import crsb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  cmd;
  logic [COUNT_W-1:0]    element_count;
  logic [SEED_W-1:0]     seed;
  logic [SLOT_IDX_W-1:0] slot_index;

  modport source (output valid, cmd, element_count, seed, slot_index, input ready);
  modport sink   (input valid, cmd, element_count, seed, slot_index, output ready);
endinterface

interface crsb_out_if import crsb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SUCC_W-1:0] successor;
  logic              status;

  modport source (output valid, successor, status, input ready);
  modport sink   (input valid, successor, status, output ready);
endinterface

### rtl/core/crsb_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module crsb_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/crsb_mod.sv
// Iterative 64-bit modulo unit, MOD_BITS_PER_CYC dividend bits per busy cycle.
module crsb_mod import crsb_pkg::*; #(
  parameter int unsigned DIV_W = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SEED_W-1:0] dividend,
  input  logic [DIV_W-1:0]  divisor,
  output logic              done,
  output logic [DIV_W-1:0]  rem
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [MOD_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SEED_W-1:0]    dvd_r, dvd_nxt;
  logic [DIV_W-1:0]     rem_r, rem_nxt;
  logic [DIV_W-1:0]     dsr_r, dsr_nxt;
  logic [DIV_W-1:0]     rem_step;

  // restoring steps, one dividend bit each
  always_comb begin
    logic [DIV_W:0]   t;
    logic [DIV_W-1:0] r;
    r = rem_r;
    for (int j = 0; j < MOD_BITS_PER_CYC; j++) begin
      t = {r, dvd_r[SEED_W-1-j]};
      if (t >= {1'b0, dsr_r}) begin
        t = t - {1'b0, dsr_r};
      end
      r = t[DIV_W-1:0];
    end
    rem_step = r;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = rem_step;
      dvd_nxt = dvd_r << MOD_BITS_PER_CYC;
      cnt_nxt = cnt_r + MOD_CNT_W'(1);
      if (cnt_r == MOD_CNT_W'(MOD_CYCLES - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

### rtl/core/crsb_ctrl.sv
// Sequencer: build fill, shuffle, successor linking and lookups over the two stores.
module crsb_ctrl import crsb_pkg::*; #(
  parameter int unsigned MAX_SLOTS = CRSB_MAX_SLOTS,
  localparam int unsigned SLOT_W = $clog2(MAX_SLOTS),
  localparam int unsigned CNT_W  = $clog2(MAX_SLOTS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  crsb_in_if.sink           in_ch,
  input  logic              out_free,
  output resp_t             resp,
  output logic              perm_we,
  output logic [SLOT_W-1:0] perm_waddr,
  output logic [SLOT_W-1:0] perm_wdata,
  output logic              perm_re,
  output logic [SLOT_W-1:0] perm_raddr,
  input  logic [SLOT_W-1:0] perm_rdata,
  output logic              succ_we,
  output logic [SLOT_W-1:0] succ_waddr,
  output logic [SLOT_W-1:0] succ_wdata,
  output logic              succ_re,
  output logic [SLOT_W-1:0] succ_raddr,
  input  logic [SLOT_W-1:0] succ_rdata,
  output logic              mod_start,
  output logic [SEED_W-1:0] mod_dividend,
  output logic [SLOT_W-1:0] mod_divisor,
  input  logic              mod_done,
  input  logic [SLOT_W-1:0] mod_rem
);

  localparam int unsigned EXT_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);

  ctrl_state_t       state_r, state_nxt;
  logic              built_r, built_nxt;
  logic [CNT_W-1:0]  ring_size_r, ring_size_nxt;
  logic [SEED_W-1:0] rng_r, rng_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SLOT_W-1:0] part_r, part_nxt;
  logic [SLOT_W-1:0] val_i_r, val_i_nxt;
  logic [SLOT_W-1:0] first_r, first_nxt;
  logic [SLOT_W-1:0] prev_r, prev_nxt;
  logic              is_read_r, is_read_nxt;
  logic              rej_r, rej_nxt;

  logic              accept;
  logic              is_read_in;
  logic [EXT_W-1:0]  count_ext;
  logic [EXT_W-1:0]  sat_ext;
  logic [CNT_W-1:0]  sat_count;
  logic              small_ring;

  assign accept     = in_ch.valid && in_ch.ready;
  assign is_read_in = (in_ch.cmd == CMD_READ);
  assign count_ext  = EXT_W'(in_ch.element_count);
  assign sat_ext    = (count_ext > EXT_W'(MAX_SLOTS)) ? EXT_W'(MAX_SLOTS) : count_ext;
  assign sat_count  = CNT_W'(sat_ext);
  assign small_ring = (sat_count < CNT_TWO);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (is_read_in || small_ring) begin
            state_nxt = ST_RESP;
          end else begin
            state_nxt = ST_FILL;
          end
        end
      end
      ST_FILL: begin
        if (cnt_r == ring_size_r - CNT_ONE) begin
          state_nxt = ST_RNG;
        end
      end
      ST_RNG:    state_nxt = ST_MOD;
      ST_MOD: begin
        if (mod_done) begin
          state_nxt = ST_SWAP_A;
        end
      end
      ST_SWAP_A: state_nxt = ST_SWAP_B;
      ST_SWAP_B: begin
        if (idx_r == SLOT_W'(1)) begin
          state_nxt = ST_LINK0;
        end else begin
          state_nxt = ST_RNG;
        end
      end
      ST_LINK0:  state_nxt = ST_LINK;
      ST_LINK: begin
        if (cnt_r == ring_size_r) begin
          state_nxt = ST_LINK_LAST;
        end
      end
      ST_LINK_LAST: state_nxt = ST_RESP;
      ST_RESP: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // store accesses never touch one entry in overlapping cycles, so no forwarding
  always_comb begin
    in_ch.ready  = 1'b0;
    resp         = '0;
    perm_we      = 1'b0;
    perm_waddr   = '0;
    perm_wdata   = '0;
    perm_re      = 1'b0;
    perm_raddr   = '0;
    succ_we      = 1'b0;
    succ_waddr   = '0;
    succ_wdata   = '0;
    succ_re      = 1'b0;
    succ_raddr   = SLOT_W'(in_ch.slot_index);
    mod_start    = 1'b0;
    mod_dividend = rng_step(rng_r);
    mod_divisor  = idx_r;
    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (accept && is_read_in) begin
          succ_re = 1'b1;
        end
        if (accept && !is_read_in && small_ring) begin
          succ_we = 1'b1;
        end
      end
      ST_FILL: begin
        perm_we    = 1'b1;
        perm_waddr = cnt_r[SLOT_W-1:0];
        perm_wdata = cnt_r[SLOT_W-1:0];
      end
      ST_RNG: begin
        perm_re    = 1'b1;
        perm_raddr = idx_r;
        mod_start  = 1'b1;
      end
      ST_MOD: begin
        if (mod_done) begin
          perm_re    = 1'b1;
          perm_raddr = mod_rem;
        end
      end
      ST_SWAP_A: begin
        perm_we    = 1'b1;
        perm_waddr = idx_r;
        perm_wdata = perm_rdata;
      end
      ST_SWAP_B: begin
        perm_we    = 1'b1;
        perm_waddr = part_r;
        perm_wdata = val_i_r;
      end
      ST_LINK0: begin
        perm_re = 1'b1;
      end
      ST_LINK: begin
        if (cnt_r != CNT_ONE) begin
          succ_we    = 1'b1;
          succ_waddr = prev_r;
          succ_wdata = perm_rdata;
        end
        if (cnt_r != ring_size_r) begin
          perm_re    = 1'b1;
          perm_raddr = cnt_r[SLOT_W-1:0];
        end
      end
      ST_LINK_LAST: begin
        succ_we    = 1'b1;
        succ_waddr = prev_r;
        succ_wdata = first_r;
      end
      ST_RESP: begin
        resp.valid     = 1'b1;
        resp.status    = rej_r ? STATUS_REJECT : STATUS_OK;
        resp.successor = (is_read_r && !rej_r) ? SUCC_W'(succ_rdata) : '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    built_nxt     = built_r;
    ring_size_nxt = ring_size_r;
    rng_nxt       = rng_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    part_nxt      = part_r;
    val_i_nxt     = val_i_r;
    first_nxt     = first_r;
    prev_nxt      = prev_r;
    is_read_nxt   = is_read_r;
    rej_nxt       = rej_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          is_read_nxt = is_read_in;
          if (is_read_in) begin
            rej_nxt = !built_r ||
                      (EXT_W'(in_ch.slot_index) >= EXT_W'(ring_size_r));
          end else begin
            rej_nxt       = 1'b0;
            built_nxt     = 1'b1;
            ring_size_nxt = sat_count;
            rng_nxt       = (in_ch.seed == '0) ? SEED_W'(1) : in_ch.seed;
            cnt_nxt       = '0;
            idx_nxt       = SLOT_W'(sat_count - CNT_ONE);
          end
        end
      end
      ST_FILL:   cnt_nxt = cnt_r + CNT_ONE;
      ST_RNG:    rng_nxt = rng_step(rng_r);
      ST_MOD: begin
        if (mod_done) begin
          val_i_nxt = perm_rdata;
          part_nxt  = mod_rem;
        end
      end
      ST_SWAP_B: idx_nxt = idx_r - SLOT_W'(1);
      ST_LINK0:  cnt_nxt = CNT_ONE;
      ST_LINK: begin
        if (cnt_r == CNT_ONE) begin
          first_nxt = perm_rdata;
        end
        prev_nxt = perm_rdata;
        if (cnt_r != ring_size_r) begin
          cnt_nxt = cnt_r + CNT_ONE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      built_r     <= 1'b0;
      ring_size_r <= '0;
      rng_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      built_r     <= built_nxt;
      ring_size_r <= ring_size_nxt;
      rng_r       <= rng_nxt;
    end
    idx_r     <= idx_nxt;
    cnt_r     <= cnt_nxt;
    part_r    <= part_nxt;
    val_i_r   <= val_i_nxt;
    first_r   <= first_nxt;
    prev_r    <= prev_nxt;
    is_read_r <= is_read_nxt;
    rej_r     <= rej_nxt;
  end

endmodule

### rtl/core/cyclic_ring_successor_builder_core.sv
// Top level of the cyclic ring successor builder: stores, sequencer, modulo unit, output register.
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+---------------------------------------
//   in_ch    | in  | valid / ready | cmd, element_count, seed, slot_index
//   out_ch   | out | valid / ready | successor, status
//
// One transaction in flight at a time; in_ch.ready is high only while the sequencer idles.
// Read: the successor store is read on acceptance and the response is issued from ST_RESP.
// Build of N >= 2 slots: a fill pass, then per shuffle step a modulo run and a swap in the
// permutation store, then a linking pass into the successor store; N < 2 goes straight to the response.
// Synchronous reset; no clearing pass. A stalled out_ch holds its result while the next
// transaction is taken and worked on; the sequencer then waits for the register to free up.
module cyclic_ring_successor_builder_core import crsb_pkg::*; #(
  parameter int unsigned MAX_SLOTS = CRSB_MAX_SLOTS
) (
  input  logic       clk,
  input  logic       rst_n,
  crsb_in_if.sink    in_ch,
  crsb_out_if.source out_ch
);

  localparam int unsigned SLOT_W = $clog2(MAX_SLOTS);

  resp_t             resp;
  logic              out_free;
  logic              perm_we, perm_re;
  logic [SLOT_W-1:0] perm_waddr, perm_wdata, perm_raddr, perm_rdata;
  logic              succ_we, succ_re;
  logic [SLOT_W-1:0] succ_waddr, succ_wdata, succ_raddr, succ_rdata;
  logic              mod_start, mod_done;
  logic [SEED_W-1:0] mod_dividend;
  logic [SLOT_W-1:0] mod_divisor, mod_rem;

  logic              out_valid_r, out_valid_nxt;
  logic [SUCC_W-1:0] out_succ_r, out_succ_nxt;
  logic              out_status_r, out_status_nxt;

  crsb_ctrl #(.MAX_SLOTS(MAX_SLOTS)) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_free     (out_free),
    .resp         (resp),
    .perm_we      (perm_we),
    .perm_waddr   (perm_waddr),
    .perm_wdata   (perm_wdata),
    .perm_re      (perm_re),
    .perm_raddr   (perm_raddr),
    .perm_rdata   (perm_rdata),
    .succ_we      (succ_we),
    .succ_waddr   (succ_waddr),
    .succ_wdata   (succ_wdata),
    .succ_re      (succ_re),
    .succ_raddr   (succ_raddr),
    .succ_rdata   (succ_rdata),
    .mod_start    (mod_start),
    .mod_dividend (mod_dividend),
    .mod_divisor  (mod_divisor),
    .mod_done     (mod_done),
    .mod_rem      (mod_rem)
  );

  crsb_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_SLOTS)) u_perm_ram (
    .clk   (clk),
    .we    (perm_we),
    .waddr (perm_waddr),
    .wdata (perm_wdata),
    .re    (perm_re),
    .raddr (perm_raddr),
    .rdata (perm_rdata)
  );

  crsb_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_SLOTS)) u_succ_ram (
    .clk   (clk),
    .we    (succ_we),
    .waddr (succ_waddr),
    .wdata (succ_wdata),
    .re    (succ_re),
    .raddr (succ_raddr),
    .rdata (succ_rdata)
  );

  crsb_mod #(.DIV_W(SLOT_W)) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (mod_dividend),
    .divisor  (mod_divisor),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_succ_nxt   = out_succ_r;
    out_status_nxt = out_status_r;
    if (resp.valid && out_free) begin
      out_valid_nxt  = 1'b1;
      out_succ_nxt   = resp.successor;
      out_status_nxt = resp.status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_succ_r   <= out_succ_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.successor = out_succ_r;
  assign out_ch.status    = out_status_r;

endmodule

### rtl/core/crsb_checker.sv
// Port-level assertions for the ring successor builder, bound to the top level.
`include "cyclic_ring_successor_builder_core_assert.svh"

module crsb_checker import crsb_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [SUCC_W-1:0] out_successor,
  input logic              out_status
);

  `CRSB_ASSERT_ALL(a_reset_idle, !rst_n |=> (!out_valid && in_ready), "reset must leave block idle and empty")
  `CRSB_ASSERT_RUN(a_accept_busy, (in_valid && in_ready) |=> !in_ready, "one transaction at a time")
  `CRSB_ASSERT_RUN(a_out_hold, (out_valid && !out_ready) |=> out_valid, "result dropped while stalled")
  `CRSB_ASSERT_RUN(a_out_stable, (out_valid && !out_ready) |=> ($stable(out_successor) && $stable(out_status)), "result changed while stalled")

endmodule

bind cyclic_ring_successor_builder_core crsb_checker u_crsb_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_successor (out_ch.successor),
  .out_status    (out_ch.status)
);

### sim/testbench.sv
// Self-checking testbench for the cyclic ring successor builder core.
`timescale 1ns / 100ps

module testbench;
  import crsb_pkg::*;

  localparam int unsigned IDLE_LIMIT = 400000;
  localparam int unsigned RANDOM_ITEMS = 1730;

  typedef struct packed {
    logic                  cmd;
    logic [COUNT_W-1:0]    count;
    logic [SEED_W-1:0]     seed;
    logic [SLOT_IDX_W-1:0] slot;
  } ring_req_t;

  typedef struct packed {
    logic [SUCC_W-1:0] successor;
    logic              status;
  } ring_ans_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  crsb_in_if  in_ch ();
  crsb_out_if out_ch ();

  cyclic_ring_successor_builder_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Ring state mirrored from the build/read semantics
  logic [SUCC_W-1:0] order [CRSB_MAX_SLOTS];
  logic [SUCC_W-1:0] next_slot [CRSB_MAX_SLOTS];
  int unsigned       ring_len = 0;
  bit                ring_valid = 1'b0;
  logic [SEED_W-1:0] rng_state = '0;

  ring_req_t   item_q [$];
  ring_ans_t   answer_q [$];
  ring_req_t   cur_req;
  int unsigned gen_len;
  int unsigned total_items = 0;
  int unsigned accepted_cnt = 0;
  int unsigned results_seen = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_wait = 0;
  int unsigned recv_wait = 0;
  int unsigned stall_left = 0;
  bit          send_burst = 1'b0;
  bit          recv_burst = 1'b0;
  logic        next_valid;
  logic        next_ready;

  function automatic logic [SEED_W-1:0] xorshift(input logic [SEED_W-1:0] s);
    logic [SEED_W-1:0] v;
    v = s;
    v = v ^ (v << RNG_SHL_A);
    v = v ^ (v >> RNG_SHR_B);
    v = v ^ (v << RNG_SHL_C);
    return v;
  endfunction

  // Sattolo shuffle, then link each permuted slot to the next one
  task automatic shuffle_ring(input int unsigned n_req, input logic [SEED_W-1:0] seed_in);
    int unsigned       n;
    int unsigned       j;
    int unsigned       k;
    logic [SEED_W-1:0] s;
    logic [SUCC_W-1:0] t;
    s = (seed_in == '0) ? 64'd1 : seed_in;
    n = (n_req > CRSB_MAX_SLOTS) ? CRSB_MAX_SLOTS : n_req;
    ring_len = n;
    ring_valid = 1'b1;
    if (n < 2) begin
      for (k = 0; k < n; k++) begin
        order[k] = '0;
        next_slot[k] = '0;
      end
      rng_state = s;
      return;
    end
    for (k = 0; k < n; k++) order[k] = SUCC_W'(k);
    for (k = n - 1; k > 0; k--) begin
      s = xorshift(s);
      j = int'(s % 64'(k));
      t = order[k];
      order[k] = order[j];
      order[j] = t;
    end
    rng_state = s;
    for (k = 0; k + 1 < n; k++) next_slot[order[k]] = order[k + 1];
    next_slot[order[n - 1]] = order[0];
  endtask

  task automatic apply_command(input ring_req_t r);
    ring_ans_t a;
    a.successor = '0;
    a.status = STATUS_OK;
    if (r.cmd == CMD_BUILD) begin
      shuffle_ring(r.count, r.seed);
    end else if (!ring_valid || r.slot >= ring_len) begin
      a.status = STATUS_REJECT;
    end else begin
      a.successor = next_slot[r.slot];
    end
    answer_q.insert(answer_q.size(), a);
  endtask

  task automatic push_build(input int unsigned cnt, input logic [SEED_W-1:0] sd);
    ring_req_t r;
    r.cmd = CMD_BUILD;
    r.count = COUNT_W'(cnt);
    r.seed = sd;
    r.slot = SLOT_IDX_W'($urandom);
    item_q.insert(item_q.size(), r);
    gen_len = (cnt > CRSB_MAX_SLOTS) ? CRSB_MAX_SLOTS : cnt;
  endtask

  task automatic push_read(input int unsigned idx);
    ring_req_t r;
    r.cmd = CMD_READ;
    r.count = COUNT_W'($urandom);
    r.seed = {$urandom, $urandom};
    r.slot = SLOT_IDX_W'(idx);
    item_q.insert(item_q.size(), r);
  endtask

  // Driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      next_valid = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        apply_command(cur_req);
        accepted_cnt++;
        next_valid = 1'b0;
        if ($urandom_range(0, 15) == 0) send_burst = !send_burst;
        send_wait = send_burst ? 0 : $urandom_range(0, 3);
      end
      if (!next_valid) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (item_q.size() > 0) begin
          cur_req = item_q.pop_front();
          in_ch.cmd <= cur_req.cmd;
          in_ch.element_count <= cur_req.count;
          in_ch.seed <= cur_req.seed;
          in_ch.slot_index <= cur_req.slot;
          next_valid = 1'b1;
        end
      end
      in_ch.valid <= next_valid;
    end
  end

  // Monitor and checker
  always @(posedge clk) begin
    ring_ans_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (answer_q.size() == 0) begin
          $display("%0t: unexpected transaction: successor %0d status %0b", $time,
                   out_ch.successor, out_ch.status);
          mismatch_cnt++;
        end else begin
          want = answer_q.pop_front();
          if (out_ch.successor !== want.successor) begin
            $display("%0t: successor mismatch: expected %0d, actual %0d", $time,
                     want.successor, out_ch.successor);
            mismatch_cnt++;
          end
          if (out_ch.status !== want.status) begin
            $display("%0t: status mismatch: expected %0b, actual %0b", $time,
                     want.status, out_ch.status);
            mismatch_cnt++;
          end
        end
        if ($urandom_range(0, 15) == 0) recv_burst = !recv_burst;
        recv_wait = recv_burst ? 0 : $urandom_range(0, 3);
        // long back-pressure so the input side stalls
        if (results_seen == 300 || results_seen == 1200) stall_left = 500;
      end
      if (stall_left > 0) begin
        stall_left--;
        next_ready = 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
      end
      out_ch.ready <= next_ready;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

  initial begin
    int unsigned i;
    int unsigned r;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_BUILD;
    in_ch.element_count = '0;
    in_ch.seed = '0;
    in_ch.slot_index = '0;
    out_ch.ready = 1'b0;
    gen_len = 0;

    // reads before any ring exists
    push_read(0);
    push_read(4095);
    // empty ring rejects everything
    push_build(0, 64'd5);
    push_read(0);
    // single slot, zero seed
    push_build(1, 64'd0);
    push_read(0);
    push_read(1);
    push_build(2, 64'd0);
    push_read(0);
    push_read(1);
    // full size ring
    push_build(4096, {SEED_W{1'b1}});
    push_read(4095);
    push_read(0);
    push_read(12'h800);
    push_read(12'hAAA);
    push_read(12'h555);
    // oversized count saturates
    push_build(8191, 64'h8000_0000_0000_0001);
    push_read(4095);
    push_build(3, 64'd1);
    push_read(0);
    push_read(1);
    push_read(2);
    push_read(3);

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 500 || i == 1100) begin
        push_build($urandom_range(4096, 8191), {$urandom, $urandom});
      end else if ($urandom_range(0, 9) == 0) begin
        r = $urandom_range(0, 39);
        if (r == 0) push_build($urandom_range(49, 700), {$urandom, $urandom});
        else if (r < 4) push_build($urandom_range(0, 1), {$urandom, $urandom});
        else if (r < 6) push_build($urandom_range(2, 48), 64'd0);
        else push_build($urandom_range(2, 48), {$urandom, $urandom});
      end else begin
        r = $urandom_range(0, 19);
        if (gen_len > 0 && r < 17) push_read($urandom_range(0, gen_len - 1));
        else if (gen_len < CRSB_MAX_SLOTS && r == 17) push_read(gen_len);
        else push_read($urandom_range(0, 4095));
      end
    end
    total_items = item_q.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (accepted_cnt != total_items || answer_q.size() != 0);
    repeat (40) @(posedge clk);

    if (mismatch_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/crsb_pkg.sv
rtl/core/crsb_if.sv
rtl/core/crsb_ram.sv
rtl/core/crsb_mod.sv
rtl/core/crsb_ctrl.sv
rtl/core/cyclic_ring_successor_builder_core.sv
rtl/core/crsb_checker.sv
sim/testbench.sv
